// ===== hdl/rfnz_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the zone search block.
package rfnz_pkg;

   localparam int MAX_ZONES   = 64;
   localparam int MAX_BEACONS = 16;
   localparam int ZONE_W      = $clog2(MAX_ZONES);
   localparam int SLOT_W      = $clog2(MAX_BEACONS);
   localparam int CNT_W       = SLOT_W + 1;
   localparam int NZ_W        = ZONE_W + 1;
   localparam int MATCH_W     = ZONE_W + 2 * SLOT_W + 1;
   localparam int K_W         = 5;
   localparam int DIST_W      = 16;
   localparam int MAC_W       = 32;
   localparam int RSSI_W      = 8;
   localparam int COORD_W     = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 7;
   localparam int REQ_DATA_W  = 88;
   localparam int RSP_DATA_W  = 56;

   localparam logic [K_W-1:0]    K_RESET   = 5'd3;
   localparam logic [DIST_W-1:0] DIST_INIT = 16'hffff;

   typedef enum logic [1:0] {
      KIND_SLOT  = 2'd0,
      KIND_ZONE  = 2'd1,
      KIND_QUERY = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_K_VALUE = 2'd0,
      CSR_ZONES   = 2'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ZREAD,
      ST_ZINIT,
      ST_SREAD,
      ST_CMP,
      ST_ZEND,
      ST_CWAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic start;
      logic zone_init;
      logic cmp_step;
      logic zone_end;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic start_search;
      logic too_few;
      logic zone_empty;
      logic q_last;
      logic j_last;
      logic zone_last;
      logic out_free;
   } status_type;

endpackage

// ===== hdl/rfnz_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rfnz_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rfnz_ctrl.sv =====
// Search sequencer state machine.
module rfnz_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  rfnz_pkg::status_type st,
   output rfnz_pkg::cmd_type   cmd
);

   rfnz_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rfnz_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rfnz_pkg::ST_IDLE:  if (st.start_search) state_in = rfnz_pkg::ST_CHECK;
         rfnz_pkg::ST_CHECK: state_in = st.too_few ? rfnz_pkg::ST_DONE : rfnz_pkg::ST_ZREAD;
         rfnz_pkg::ST_ZREAD: state_in = rfnz_pkg::ST_ZINIT;
         rfnz_pkg::ST_ZINIT: state_in = st.zone_empty ? rfnz_pkg::ST_ZEND : rfnz_pkg::ST_SREAD;
         rfnz_pkg::ST_SREAD: state_in = rfnz_pkg::ST_CMP;
         rfnz_pkg::ST_CMP: begin
            if (st.q_last) begin
               state_in = st.j_last ? rfnz_pkg::ST_ZEND : rfnz_pkg::ST_SREAD;
            end
         end
         rfnz_pkg::ST_ZEND:  state_in = st.zone_last ? rfnz_pkg::ST_CWAIT : rfnz_pkg::ST_ZREAD;
         rfnz_pkg::ST_CWAIT: state_in = rfnz_pkg::ST_DONE;
         rfnz_pkg::ST_DONE:  if (st.out_free) state_in = rfnz_pkg::ST_IDLE;
         default:            state_in = rfnz_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         rfnz_pkg::ST_IDLE:  cmd.accept    = 1'b1;
         rfnz_pkg::ST_CHECK: cmd.start     = 1'b1;
         rfnz_pkg::ST_ZINIT: cmd.zone_init = 1'b1;
         rfnz_pkg::ST_CMP:   cmd.cmp_step  = 1'b1;
         rfnz_pkg::ST_ZEND:  cmd.zone_end  = 1'b1;
         rfnz_pkg::ST_DONE:  cmd.out_load  = st.out_free;
         default:            cmd = '0;
      endcase
   end

`ifndef ASSERT_OFF
   a_done_from_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rfnz_pkg::ST_DONE && $past(state_ff) != rfnz_pkg::ST_DONE)
      |-> ($past(state_ff) == rfnz_pkg::ST_CWAIT || $past(state_ff) == rfnz_pkg::ST_CHECK))
      else $error("result stage entered without finishing search");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command");
   a_cmp_after_read: assert property (@(posedge clock) disable iff (reset)
      (cmd.cmp_step && $past(state_ff) != rfnz_pkg::ST_CMP) |-> $past(state_ff) == rfnz_pkg::ST_SREAD)
      else $error("compare without slot read");
`endif

endmodule

// ===== hdl/rfnz_dpath.sv =====
// Storage, counters and distance accumulation for the zone search.
module rfnz_dpath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rfnz_pkg::cmd_type                      cmd,
   output rfnz_pkg::status_type                   st,
   input  logic                                   req_tvalid,
   input  logic [rfnz_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  logic [1:0]                             req_tuser,
   input  logic                                   req_tlast,
   input  logic                                   csr_valid,
   input  logic [rfnz_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [rfnz_pkg::CSR_DATA_W-1:0]        csr_data,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [rfnz_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tuser
);

   localparam int ZW  = rfnz_pkg::ZONE_W;
   localparam int SW  = rfnz_pkg::SLOT_W;
   localparam int CW  = rfnz_pkg::CNT_W;
   localparam int MW  = rfnz_pkg::MAC_W;
   localparam int RW  = rfnz_pkg::RSSI_W;
   localparam int XW  = rfnz_pkg::COORD_W;
   localparam int DW  = rfnz_pkg::DIST_W;
   localparam int KW  = rfnz_pkg::K_W;
   localparam int NW  = rfnz_pkg::NZ_W;
   localparam int AW  = rfnz_pkg::MATCH_W;

   // request fields
   logic [ZW-1:0] f_zone;
   logic [SW-1:0] f_slot;
   logic [MW-1:0] f_mac;
   logic [RW-1:0] f_rssi;
   logic [XW-1:0] f_x, f_y;
   logic [CW-1:0] f_count, f_count_cap;
   logic          acc;
   rfnz_pkg::kind_type f_kind;

   assign f_zone  = req_tdata[5:0];
   assign f_slot  = req_tdata[9:6];
   assign f_mac   = req_tdata[41:10];
   assign f_rssi  = req_tdata[49:42];
   assign f_x     = req_tdata[65:50];
   assign f_y     = req_tdata[81:66];
   assign f_count = req_tdata[86:82];
   assign f_kind  = rfnz_pkg::kind_type'(req_tuser);
   assign acc     = req_tvalid && cmd.accept;
   assign f_count_cap = (f_count > CW'(rfnz_pkg::MAX_BEACONS)) ?
                        CW'(rfnz_pkg::MAX_BEACONS) : f_count;

   logic [KW-1:0] k_ff;
   logic [NW-1:0] nz_ff, nz_eff;
   logic [CW-1:0] held_ff;
   logic [MW-1:0] qmac_ff  [rfnz_pkg::MAX_BEACONS];
   logic [RW-1:0] qrssi_ff [rfnz_pkg::MAX_BEACONS];
   logic [rfnz_pkg::MAX_ZONES-1:0] zvalid_ff;
   logic [ZW-1:0] zone_ff, best_zone_ff;
   logic [SW-1:0] j_ff, q_ff;
   logic [CW-1:0] ns_ff, ns_in;
   logic [DW-1:0] d_ff, best_d_ff;
   logic [AW-1:0] cnt_ff;
   logic          hit_ff;
   logic          rsp_valid_ff;
   logic          found_ff;
   logic [rfnz_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic [MW+RW-1:0] slot_rd;
   logic [CW-1:0]    count_rd;
   logic [2*XW-1:0]  coord_rd;

   rfnz_ram #(.WIDTH(MW + RW), .DEPTH(rfnz_pkg::MAX_ZONES * rfnz_pkg::MAX_BEACONS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (acc && f_kind == rfnz_pkg::KIND_SLOT),
      .wr_addr ({f_zone, f_slot}),
      .wr_data ({f_mac, f_rssi}),
      .rd_addr ({zone_ff, j_ff}),
      .rd_data (slot_rd)
   );

   rfnz_ram #(.WIDTH(CW), .DEPTH(rfnz_pkg::MAX_ZONES)) u_count_ram (
      .clock   (clock),
      .wr_en   (acc && f_kind == rfnz_pkg::KIND_ZONE),
      .wr_addr (f_zone),
      .wr_data (f_count_cap),
      .rd_addr (zone_ff),
      .rd_data (count_rd)
   );

   rfnz_ram #(.WIDTH(2 * XW), .DEPTH(rfnz_pkg::MAX_ZONES)) u_coord_ram (
      .clock   (clock),
      .wr_en   (acc && f_kind == rfnz_pkg::KIND_ZONE),
      .wr_addr (f_zone),
      .wr_data ({f_y, f_x}),
      .rd_addr (best_zone_ff),
      .rd_data (coord_rd)
   );

   // distance term of one slot against one query pair
   logic [MW-1:0] s_mac;
   logic signed [RW:0] diff;
   logic [RW-1:0]  adiff;
   logic           match;

   assign s_mac = slot_rd[MW+RW-1:RW];
   assign diff  = $signed({slot_rd[RW-1], slot_rd[RW-1:0]}) -
                  $signed({qrssi_ff[q_ff][RW-1], qrssi_ff[q_ff]});
   assign adiff = diff[RW] ? RW'(-diff) : diff[RW-1:0];
   assign match = (s_mac == qmac_ff[q_ff]);

   assign nz_eff = (nz_ff > NW'(rfnz_pkg::MAX_ZONES)) ? NW'(rfnz_pkg::MAX_ZONES) : nz_ff;
   assign ns_in  = zvalid_ff[zone_ff] ? count_rd : '0;

   assign st.start_search = acc && f_kind == rfnz_pkg::KIND_QUERY && req_tlast;
   assign st.too_few      = (held_ff < CW'(k_ff)) || (nz_ff == '0);
   assign st.zone_empty   = (ns_in == '0) || (k_ff == '0);
   assign st.q_last       = ({1'b0, q_ff} == k_ff - KW'(1));
   assign st.j_last       = ({1'b0, j_ff} == ns_ff - CW'(1));
   assign st.zone_last    = ({1'b0, zone_ff} + NW'(1) == nz_eff);
   assign st.out_free     = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= rfnz_pkg::K_RESET;
         nz_ff        <= '0;
         held_ff      <= '0;
         zvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (rfnz_pkg::csr_index_type'(csr_index))
               rfnz_pkg::CSR_K_VALUE: k_ff  <= csr_data[KW-1:0];
               rfnz_pkg::CSR_ZONES:   nz_ff <= csr_data[NW-1:0];
               default: ;
            endcase
         end
         if (acc && f_kind == rfnz_pkg::KIND_ZONE) begin
            zvalid_ff[f_zone] <= 1'b1;
         end
         if (cmd.start) begin
            held_ff <= '0;
         end else if (acc && f_kind == rfnz_pkg::KIND_QUERY &&
                      held_ff < CW'(rfnz_pkg::MAX_BEACONS)) begin
            held_ff <= held_ff + CW'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc && f_kind == rfnz_pkg::KIND_QUERY && held_ff < CW'(rfnz_pkg::MAX_BEACONS)) begin
         qmac_ff[held_ff[SW-1:0]]  <= f_mac;
         qrssi_ff[held_ff[SW-1:0]] <= f_rssi;
      end
      if (cmd.start) begin
         zone_ff      <= '0;
         best_zone_ff <= '0;
         best_d_ff    <= rfnz_pkg::DIST_INIT;
         hit_ff       <= 1'b0;
      end
      if (cmd.zone_init) begin
         ns_ff  <= ns_in;
         d_ff   <= '0;
         cnt_ff <= '0;
         j_ff   <= '0;
         q_ff   <= '0;
      end
      if (cmd.cmp_step) begin
         if (match) begin
            d_ff   <= d_ff + DW'(adiff);
            cnt_ff <= cnt_ff + AW'(1);
         end
         if (st.q_last) begin
            q_ff <= '0;
            j_ff <= j_ff + SW'(1);
         end else begin
            q_ff <= q_ff + SW'(1);
         end
      end
      if (cmd.zone_end) begin
         if (d_ff < best_d_ff && cnt_ff >= AW'(k_ff)) begin
            best_d_ff    <= d_ff;
            best_zone_ff <= zone_ff;
            hit_ff       <= 1'b1;
         end
         zone_ff <= zone_ff + ZW'(1);
      end
      if (cmd.out_load) begin
         found_ff <= hit_ff;
         if (hit_ff) begin
            rsp_data_ff <= {2'b00, best_d_ff, coord_rd[2*XW-1:XW], coord_rd[XW-1:0], best_zone_ff};
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = found_ff;

`ifndef ASSERT_OFF
   a_held_cap: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CW'(rfnz_pkg::MAX_BEACONS))
      else $error("query pair count overflow");
   a_hit_dist: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && hit_ff) |-> best_d_ff != rfnz_pkg::DIST_INIT)
      else $error("winning zone with initial distance");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result transfer lost");
   a_cmp_range: assert property (@(posedge clock) disable iff (reset)
      cmd.cmp_step |-> ({1'b0, q_ff} < k_ff && {1'b0, j_ff} < ns_ff))
      else $error("compare index out of range");
`endif

endmodule

// ===== hdl/rssi_fingerprint_nearest_zone_top.sv =====
// Top level of the fingerprint nearest-zone search block.
//
//  channel | ports                           | payload
//  req     | req_tvalid/tready/tdata/tuser/tlast | tdata: zone_index, slot_index, beacon_mac,
//          |                                 |   beacon_rssi, zone_x, zone_y, beacon_count;
//          |                                 |   tuser: kind; tlast: query_last
//  rsp     | rsp_tvalid/tready/tdata/tuser   | tdata: best_zone, best_x, best_y, best_distance;
//          |                                 |   tuser: found
//  csr     | csr_valid/ready/index/data      | index 0 k_value, 1 zones_in_use
//
// Load and query items are taken only while idle; no item is taken while a search runs.
// A search walks every zone in use, comparing each of its slots with the k_value query pairs,
// one compare per cycle, with a read on the single slot RAM read port before each slot.
// Reset is synchronous; the zone table holds no clearing pass, only per-zone valid bits.
// A pending result waits in the output register while the next items are taken.
module rssi_fingerprint_nearest_zone_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [5:0] zone_index, [9:6] slot_index, [41:10] beacon_mac, [49:42] beacon_rssi,
   // [65:50] zone_x, [81:66] zone_y, [86:82] beacon_count
   input  logic [rfnz_pkg::REQ_DATA_W-1:0]       req_tdata,
   // [1:0] kind
   input  logic [1:0]                            req_tuser,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [5:0] best_zone, [21:6] best_x, [37:22] best_y, [53:38] best_distance
   output logic [rfnz_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // [0] found
   output logic                                  rsp_tuser,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rfnz_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rfnz_pkg::CSR_DATA_W-1:0]       csr_data
);

   rfnz_pkg::cmd_type    cmd;
   rfnz_pkg::status_type st;

   assign req_tready = cmd.accept;
   assign csr_ready  = 1'b1;

   rfnz_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   rfnz_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
